>>> sv/pfsf_pkg.sv
// Package for the progression-free set filter.
// Item types, outcome codes, controller/datapath link types, default sizes.
// No dependencies.
package pfsf_pkg;

   localparam int SET_DEPTH_DEFAULT  = 64;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam logic       REQ_CLEAR = 1'b0;
   localparam logic       REQ_OFFER = 1'b1;

   localparam logic [2:0] OUT_STORED    = 3'd0;
   localparam logic [2:0] OUT_EQUATION  = 3'd1;
   localparam logic [2:0] OUT_FULL      = 3'd2;
   localparam logic [2:0] OUT_DUPLICATE = 3'd3;
   localparam logic [2:0] OUT_CLEARED   = 3'd4;

   typedef struct packed {
      logic        req_type;
      logic [15:0] candidate_value;
   } pfsf_req_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] outcome;
      logic [6:0] members_held;
   } pfsf_rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } pfsf_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic count_zero;
      logic last_pair;
      logic out_hold;
   } pfsf_stat_type;

endpackage

>>> sv/pfsf_ctrl.sv
// Controller for the progression-free set filter.
// Sequences accept, pair scan, drain and commit. Depends on pfsf_pkg.
module pfsf_ctrl
   import pfsf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  pfsf_stat_type stat,
   output pfsf_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.is_clear || stat.count_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
               if (stat.last_pair) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.out_hold) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/pfsf_dpath.sv
// Datapath for the progression-free set filter.
// Member memory, pair indices, equation checks, count and result register.
// Depends on pfsf_pkg.
module pfsf_dpath
   import pfsf_pkg::*;
#(
   parameter int SET_DEPTH  = SET_DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  pfsf_req_type  req_data,
   input  pfsf_cmd_type  cmd,
   output pfsf_stat_type stat,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output pfsf_rsp_type  rsp_data
);

   localparam int IW = $clog2(SET_DEPTH);
   localparam int CW = $clog2(SET_DEPTH + 1);
   localparam int SW = VALUE_BITS + 2;

   logic [VALUE_BITS-1:0] mem [SET_DEPTH];

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [VALUE_BITS-1:0] v_ff;
   logic                  clr_ff;
   logic [IW-1:0]         i_ff;
   logic [IW-1:0]         j_ff;
   logic [VALUE_BITS-1:0] p_ff;
   logic [VALUE_BITS-1:0] q_ff;
   logic                  vld_ff;
   logic                  ne_ff;
   logic                  dup_ff;
   logic                  eq_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   pfsf_rsp_type          rsp_data_ff;
   pfsf_rsp_type          rsp_data_in;

   logic [IW-1:0] last_idx;
   logic [SW-1:0] v_w;
   logic [SW-1:0] p_w;
   logic [SW-1:0] q_w;
   logic          eq_hit;
   logic          full;
   logic          store_en;

   assign last_idx = IW'(count_ff - CW'(1));
   assign v_w      = SW'(v_ff);
   assign p_w      = SW'(p_ff);
   assign q_w      = SW'(q_ff);
   assign full     = (count_ff == CW'(SET_DEPTH));

   // v+p=2q, p+q=2v, v+2p=3q, p+2v=3q, p+2q=3v
   assign eq_hit = (v_w + p_w == (q_w << 1))
                || (p_w + q_w == (v_w << 1))
                || (v_w + (p_w << 1) == (q_w << 1) + q_w)
                || (p_w + (v_w << 1) == (q_w << 1) + q_w)
                || (p_w + (q_w << 1) == (v_w << 1) + v_w);

   assign stat.is_clear   = (clr_ff == REQ_CLEAR);
   assign stat.count_zero = (count_ff == '0);
   assign stat.last_pair  = (i_ff == last_idx) && (j_ff == last_idx);
   assign stat.out_hold   = rsp_valid_ff && rsp_stall;

   always_comb begin
      store_en    = 1'b0;
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.finish) begin
         rsp_data_in.accepted = 1'b0;
         priority if (clr_ff == REQ_CLEAR) begin
            count_in                = '0;
            rsp_data_in.outcome     = OUT_CLEARED;
         end else if (dup_ff) begin
            rsp_data_in.outcome     = OUT_DUPLICATE;
         end else if (full) begin
            rsp_data_in.outcome     = OUT_FULL;
         end else if (eq_ff) begin
            rsp_data_in.outcome     = OUT_EQUATION;
         end else begin
            store_en                = 1'b1;
            count_in                = count_ff + CW'(1);
            rsp_data_in.accepted    = 1'b1;
            rsp_data_in.outcome     = OUT_STORED;
         end
         rsp_data_in.members_held = 7'(count_in);
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      p_ff <= mem[i_ff];
      q_ff <= mem[j_ff];
      if (store_en) begin
         mem[IW'(count_ff)] <= v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      ne_ff       <= (i_ff != j_ff);
      if (cmd.load) begin
         v_ff   <= VALUE_BITS'(req_data.candidate_value);
         clr_ff <= req_data.req_type;
         i_ff   <= '0;
         j_ff   <= '0;
         dup_ff <= 1'b0;
         eq_ff  <= 1'b0;
      end else begin
         if (cmd.scan) begin
            if (j_ff == last_idx) begin
               j_ff <= '0;
               i_ff <= i_ff + IW'(1);
            end else begin
               j_ff <= j_ff + IW'(1);
            end
         end
         if (vld_ff) begin
            dup_ff <= dup_ff || (p_ff == v_ff);
            eq_ff  <= eq_ff || (ne_ff && eq_hit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         vld_ff       <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/progression_free_set_filter_top.sv
// Top level of the progression-free set filter.
// Joins pfsf_ctrl and pfsf_dpath. Depends on pfsf_pkg.
//
// Usage:
//   req channel: req_valid/req_stall with req_data (req_type, candidate_value).
//     req_type clear empties the set; offer tests candidate_value for entry.
//   rsp channel: rsp_valid/rsp_stall with rsp_data (accepted, outcome,
//     members_held); exactly one item per request, in order.
//   Flow: a clear or an offer to an empty set skips the pair scan and goes
//   straight to commit. An offer to a set of n members walks every ordered
//   pair of stored entries, one pair per cycle through the two read ports
//   of the member memory, then passes a drain state that lets the compare
//   stage finish before commit.
//   One item is processed at a time; req_stall is high from accept to
//   commit of the result, so the next item is taken in the cycle after commit.
//   The result sits in an output register; the next item may be accepted
//   while it waits. If rsp_stall holds the register, the following item
//   waits at its commit step until the register frees up.
//   Reset (synchronous) empties the set and drops any pending result.
module progression_free_set_filter_top
   import pfsf_pkg::*;
#(
   parameter int SET_DEPTH  = SET_DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pfsf_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pfsf_rsp_type rsp_data
);

   pfsf_cmd_type  cmd;
   pfsf_stat_type stat;

   pfsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfsf_dpath #(
      .SET_DEPTH  (SET_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
